// File: rtl/colour_temperature_to_rgb_macros.svh
// ----------------------------------------------------------------------------
// colour temperature to rgb assertion macros
// immediate-free concurrent checks, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef COLOUR_TEMPERATURE_TO_RGB_MACROS_SVH
`define COLOUR_TEMPERATURE_TO_RGB_MACROS_SVH

`ifndef SYNTHESIS

`define CTRGB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define CTRGB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define CTRGB_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CTRGB_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: rtl/ctrgb_pkg.sv
// ----------------------------------------------------------------------------
// ctrgb_pkg
// constants, tables and shared arithmetic of the colour temperature converter
// ----------------------------------------------------------------------------
package ctrgb_pkg;

   localparam int LEVEL_BITS_DEFAULT = 8;
   localparam int TEMP_W  = 16;
   localparam int LOG_W   = 28;
   localparam int MANT_W  = 31;
   localparam int FRAC_W  = 24;
   localparam int Q_W     = 32;
   localparam int EXPM_W  = 18;
   localparam int LOG_LAT = 25;

   localparam logic [TEMP_W-1:0] T_KNEE      = 16'd6600;
   localparam logic [TEMP_W-1:0] T_BLUE_LO   = 16'd2000;
   localparam logic [TEMP_W-1:0] T_BLUE_HI   = 16'd6500;
   localparam logic [TEMP_W-1:0] T_HI_OFFSET = 16'd6000;
   localparam logic [TEMP_W-1:0] T_BL_OFFSET = 16'd1000;

   localparam logic signed [Q_W-1:0] Q_ONE    = 32'sd16777216;
   localparam logic signed [Q_W-1:0] LOG2_100 = 32'sd111465410;
   localparam logic signed [Q_W-1:0] RED_K    = 32'sd6123760;
   localparam logic signed [Q_W-1:0] RED_P    = -32'sd2234805;
   localparam logic signed [Q_W-1:0] GRN_HI_K = 32'sd2861134;
   localparam logic signed [Q_W-1:0] GRN_HI_P = -32'sd1266929;
   localparam logic signed [Q_W-1:0] GRN_LO_A = 32'sd4518570;
   localparam logic signed [Q_W-1:0] GRN_LO_B = 32'sd10559132;
   localparam logic signed [Q_W-1:0] BLU_A    = 32'sd6292319;
   localparam logic signed [Q_W-1:0] BLU_B    = 32'sd19991416;
   localparam logic signed [Q_W-1:0] EXP_MIN  = -32'sd671088640;
   localparam logic signed [Q_W-1:0] EXP_BIAS = 32'sd1073741824;

   typedef struct packed {
      logic              full;
      logic              zero;
      logic [5:0]        ip;
      logic [EXPM_W-1:0] mant;
   } exp_prep_type;

   function automatic logic [EXPM_W-1:0] exp2_tab(input logic [4:0] idx);
      case (idx)
         5'd0:    exp2_tab = 18'd65536;
         5'd1:    exp2_tab = 18'd68438;
         5'd2:    exp2_tab = 18'd71468;
         5'd3:    exp2_tab = 18'd74632;
         5'd4:    exp2_tab = 18'd77936;
         5'd5:    exp2_tab = 18'd81386;
         5'd6:    exp2_tab = 18'd84990;
         5'd7:    exp2_tab = 18'd88752;
         5'd8:    exp2_tab = 18'd92682;
         5'd9:    exp2_tab = 18'd96785;
         5'd10:   exp2_tab = 18'd101070;
         5'd11:   exp2_tab = 18'd105545;
         5'd12:   exp2_tab = 18'd110218;
         5'd13:   exp2_tab = 18'd115098;
         5'd14:   exp2_tab = 18'd120194;
         5'd15:   exp2_tab = 18'd125515;
         5'd16:   exp2_tab = 18'd131072;
         default: exp2_tab = 18'd131072;
      endcase
   endfunction

   // q24 product, rounded half away from zero
   function automatic logic signed [Q_W-1:0] mul_q24(input logic signed [Q_W-1:0] a,
                                                     input logic signed [Q_W-1:0] c);
      logic        neg;
      logic [30:0] ma;
      logic [23:0] mc;
      logic [55:0] prod;
      logic [31:0] mag;
      neg  = a[Q_W-1] ^ c[Q_W-1];
      ma   = a[Q_W-1] ? 31'(-a) : 31'(a);
      mc   = c[Q_W-1] ? 24'(-c) : 24'(c);
      prod = 56'(ma * mc) + 56'(1 << 23);
      mag  = 32'(prod >> 24);
      mul_q24 = neg ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic exp_prep_type exp_prep(input logic signed [Q_W-1:0] e);
      logic [Q_W-1:0]    s;
      logic [4:0]        idx;
      logic [19:0]       rem;
      logic [12:0]       diff;
      logic [33:0]       interp;
      exp_prep_type      res;
      s          = $unsigned(e + EXP_BIAS);
      idx        = {1'b0, s[23:20]};
      rem        = s[19:0];
      diff       = 13'(exp2_tab(idx + 5'd1) - exp2_tab(idx));
      interp     = 34'(diff * rem) + 34'(1 << 19);
      res.full   = !e[Q_W-1];
      res.zero   = e < EXP_MIN;
      res.ip     = s[29:24];
      res.mant   = exp2_tab(idx) + EXPM_W'(interp >> 20);
      exp_prep   = res;
   endfunction

endpackage

// File: rtl/ctrgb_if.sv
// ----------------------------------------------------------------------------
// ctrgb channels
// valid/ready channels for temperature requests and rgb responses
// ----------------------------------------------------------------------------
interface ctrgb_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] temperature_k;

   modport source (output valid, output temperature_k, input ready);
   modport sink   (input valid, input temperature_k, output ready);
endinterface

interface ctrgb_rsp_if #(
   parameter int LEVEL_BITS = 8
);
   logic                  valid;
   logic                  ready;
   logic [LEVEL_BITS-1:0] red_level;
   logic [LEVEL_BITS-1:0] green_level;
   logic [LEVEL_BITS-1:0] blue_level;

   modport source (output valid, output red_level, output green_level,
                   output blue_level, input ready);
   modport sink   (input valid, input red_level, input green_level,
                   input blue_level, output ready);
endinterface

// File: rtl/ctrgb_log2.sv
// ----------------------------------------------------------------------------
// ctrgb_log2
// pipelined log2 in q24, one squaring stage per fraction bit
// ----------------------------------------------------------------------------
module ctrgb_log2 import ctrgb_pkg::*; (
   input  logic              clock,
   input  logic              enable,
   input  logic [TEMP_W-1:0] u_in,
   output logic [LOG_W-1:0]  log_out
);

   logic [MANT_W-1:0]   m_ff [0:FRAC_W];
   logic [LOG_W-1:0]    r_ff [0:FRAC_W];
   logic [MANT_W-1:0]   m_in [0:FRAC_W];
   logic [LOG_W-1:0]    r_in [0:FRAC_W];
   logic [2*MANT_W-1:0] sq   [0:FRAC_W-1];
   logic [31:0]         hi   [0:FRAC_W-1];
   logic [3:0]          msb;

   // normalize, then one squaring per fraction bit
   always_comb begin
      msb = '0;
      for (int i = 1; i < TEMP_W; i++) begin
         if (u_in[i]) msb = 4'(i);
      end
      m_in[0] = MANT_W'(u_in) << (5'd30 - {1'b0, msb});
      r_in[0] = {msb, {FRAC_W{1'b0}}};
      for (int g = 0; g < FRAC_W; g++) begin
         sq[g]     = m_ff[g] * m_ff[g];
         hi[g]     = sq[g][61:30];
         m_in[g+1] = hi[g][31] ? hi[g][31:1] : hi[g][30:0];
         r_in[g+1] = r_ff[g] | (LOG_W'(hi[g][31]) << (FRAC_W - 1 - g));
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k <= FRAC_W; k++) begin
            m_ff[k] <= m_in[k];
            r_ff[k] <= r_in[k];
         end
      end
   end

   assign log_out = r_ff[FRAC_W];

endmodule

// File: rtl/colour_temperature_to_rgb.sv
// ----------------------------------------------------------------------------
// colour_temperature_to_rgb
// colour temperature in kelvin to red, green and blue drive levels
// ----------------------------------------------------------------------------
// usage
//   req_chan carries temperature_k; a transfer happens when valid and ready
//   are both high. rsp_chan returns red_level, green_level and blue_level,
//   each LEVEL_BITS wide with all ones meaning full intensity.
//   one response per request, in request order.
//   from request transfer to response valid the data passes 25 log2
//   stages (normalize plus one squaring multiplier per fraction bit), then
//   offset, product, sum, exp2 table, scale and round/clamp stages.
//   throughput is one transfer per cycle while no response waits untaken.
//   when the receiver stalls, the whole pipeline holds; req_chan.ready drops
//   only while a response waits and is not taken.
//   reset (synchronous, active high) clears all valid bits; in-flight items
//   are dropped.
// ----------------------------------------------------------------------------
`include "colour_temperature_to_rgb_macros.svh"

module colour_temperature_to_rgb import ctrgb_pkg::*; #(
   parameter int LEVEL_BITS = LEVEL_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   ctrgb_req_if.sink   req_chan,
   ctrgb_rsp_if.source rsp_chan
);

   localparam int LAST  = LOG_LAT + 5;
   localparam int PW    = LEVEL_BITS + EXPM_W;
   localparam logic [LEVEL_BITS-1:0] FULL = '1;

   logic                      en;
   logic                      v_ff [0:LAST];
   logic [TEMP_W-1:0]         t_ff [0:LAST];
   logic [TEMP_W-1:0]         ua, ub;
   logic [LOG_W-1:0]          loga, logb;

   logic signed [Q_W-1:0]     lxa_ff, lxb_ff;
   logic signed [Q_W-1:0]     pr_ff, pg_ff, pb_ff;
   logic signed [Q_W-1:0]     er_ff, eg_ff, fb_ff;
   exp_prep_type              xr_ff, xg_ff, xr2_ff, xg2_ff;
   logic [LEVEL_BITS-1:0]     glin_ff, blin_ff, glin2_ff, blin2_ff;
   logic [PW-1:0]             prodr_ff, prodg_ff;
   logic [LEVEL_BITS-1:0]     red_ff, green_ff, blue_ff;
   logic [LEVEL_BITS-1:0]     red_in, green_in, blue_in;
   logic                      low_b, low_c, low_f;

   function automatic logic [LEVEL_BITS-1:0] lin_level(input logic signed [Q_W-1:0] f);
      logic [LEVEL_BITS+FRAC_W:0] p;
      p = (LEVEL_BITS+FRAC_W+1)'(FULL * f[FRAC_W-1:0]) + (LEVEL_BITS+FRAC_W+1)'(1 << 23);
      if (f <= 0)          lin_level = '0;
      else if (f >= Q_ONE) lin_level = FULL;
      else                 lin_level = LEVEL_BITS'(p >> FRAC_W);
   endfunction

   function automatic logic [LEVEL_BITS-1:0] exp_final(input exp_prep_type x,
                                                       input logic [PW-1:0] prod);
      logic [6:0]  sh;
      logic [PW:0] sum;
      logic [PW:0] q;
      sh  = 7'd80 - {1'b0, x.ip};
      sum = {1'b0, prod} + ((PW+1)'(1) << (sh - 7'd1));
      q   = sum >> sh;
      if (x.full)                 exp_final = FULL;
      else if (x.zero || sh > 40) exp_final = '0;
      else if (q > (PW+1)'(FULL)) exp_final = FULL;
      else                        exp_final = LEVEL_BITS'(q);
   endfunction

   assign en             = !v_ff[LAST] || rsp_chan.ready;
   assign req_chan.ready = en;

   assign ua = (req_chan.temperature_k < T_KNEE) ? req_chan.temperature_k
                                                 : req_chan.temperature_k - T_HI_OFFSET;
   assign ub = req_chan.temperature_k - T_BL_OFFSET;

   ctrgb_log2 u_log_a (.clock(clock), .enable(en), .u_in(ua), .log_out(loga));
   ctrgb_log2 u_log_b (.clock(clock), .enable(en), .u_in(ub), .log_out(logb));

   // valid and temperature travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LAST; k++) v_ff[k] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= req_chan.valid;
         for (int k = 1; k <= LAST; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff[0] <= req_chan.temperature_k;
         for (int k = 1; k <= LAST; k++) t_ff[k] <= t_ff[k-1];
      end
   end

   assign low_b = t_ff[LOG_LAT] < T_KNEE;
   assign low_c = t_ff[LOG_LAT+1] < T_KNEE;
   assign low_f = t_ff[LAST-1] < T_KNEE;

   always_comb begin
      if (low_f) red_in = FULL;
      else       red_in = exp_final(xr2_ff, prodr_ff);
      if (t_ff[LAST-1] == '0) green_in = '0;
      else if (low_f)         green_in = glin2_ff;
      else                    green_in = exp_final(xg2_ff, prodg_ff);
      if (t_ff[LAST-1] < T_BLUE_LO)      blue_in = '0;
      else if (t_ff[LAST-1] > T_BLUE_HI) blue_in = FULL;
      else                               blue_in = blin2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // offset
         lxa_ff   <= $signed(Q_W'(loga)) - LOG2_100;
         lxb_ff   <= $signed(Q_W'(logb)) - LOG2_100;
         // products
         pr_ff    <= mul_q24(lxa_ff, RED_P);
         pg_ff    <= mul_q24(lxa_ff, low_b ? GRN_LO_A : GRN_HI_P);
         pb_ff    <= mul_q24(lxb_ff, BLU_A);
         // sums
         er_ff    <= RED_K + pr_ff;
         eg_ff    <= low_c ? pg_ff - GRN_LO_B : GRN_HI_K + pg_ff;
         fb_ff    <= pb_ff - BLU_B;
         // exp2 table and linear levels
         xr_ff    <= exp_prep(er_ff);
         xg_ff    <= exp_prep(eg_ff);
         glin_ff  <= lin_level(eg_ff);
         blin_ff  <= lin_level(fb_ff);
         // scale
         prodr_ff <= PW'(FULL * xr_ff.mant);
         prodg_ff <= PW'(FULL * xg_ff.mant);
         xr2_ff   <= xr_ff;
         xg2_ff   <= xg_ff;
         glin2_ff <= glin_ff;
         blin2_ff <= blin_ff;
         // round, clamp, select
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_chan.valid       = v_ff[LAST];
   assign rsp_chan.red_level   = red_ff;
   assign rsp_chan.green_level = green_ff;
   assign rsp_chan.blue_level  = blue_ff;

   `CTRGB_ASSERT_IMP(a_red_full_low, clock, reset, v_ff[LAST] && t_ff[LAST] < T_KNEE, red_ff == FULL)
   `CTRGB_ASSERT_IMP(a_blue_zero_low, clock, reset, v_ff[LAST] && t_ff[LAST] < T_BLUE_LO, blue_ff == '0)
   `CTRGB_ASSERT_IMP(a_blue_full_high, clock, reset, v_ff[LAST] && t_ff[LAST] > T_BLUE_HI, blue_ff == FULL)
   `CTRGB_ASSERT_NXT(a_stall_holds, clock, reset, v_ff[LAST] && !rsp_chan.ready, v_ff[LAST] && $stable(t_ff[LAST]))

endmodule
